>>> design/sorted_date_history_table_assert.svh
// Assertion macros shared by the history table RTL.
`ifndef SORTED_DATE_HISTORY_TABLE_ASSERT_SVH
`define SORTED_DATE_HISTORY_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check an expression at every clock edge outside reset.
`define SDHT_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sdht: invariant violated");

// Check a consequence in the same cycle as its cause.
`define SDHT_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdht: same-cycle implication violated");

// Check a consequence in the cycle after its cause.
`define SDHT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdht: next-cycle implication violated");

`else

`define SDHT_ASSERT_ALWAYS(name, clk, rst, expr)
`define SDHT_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define SDHT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> design/sdht_pkg.sv
package sdht_pkg;

   localparam int DEFAULT_DEPTH = 64;

   localparam int YEAR_W        = 12;
   localparam int MONTH_W       = 4;
   localparam int DAY_W         = 5;
   localparam int DATE_W        = YEAR_W + MONTH_W + DAY_W;
   localparam int HANDLE_W      = 32;
   localparam int ENTRY_INDEX_W = 6;
   localparam int ENTRY_COUNT_W = 7;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_READ   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_MISSING   = 2'd2,
      ST_FULL      = 2'd3
   } status_code_type;

   typedef struct packed {
      req_code_type                   req_type;
      logic [YEAR_W-1:0]              year;
      logic [MONTH_W-1:0]             month;
      logic [DAY_W-1:0]               day;
      logic [HANDLE_W-1:0]            value_handle;
      logic [ENTRY_INDEX_W-1:0]       entry_index;
   } sdht_req_type;

   typedef struct packed {
      status_code_type                status;
      logic [HANDLE_W-1:0]            found_handle;
      logic [YEAR_W-1:0]              found_year;
      logic [MONTH_W-1:0]             found_month;
      logic [DAY_W-1:0]               found_day;
      logic [ENTRY_COUNT_W-1:0]       entry_count;
   } sdht_rsp_type;

   // One stored entry: packed date key and its handle.
   typedef struct packed {
      logic [DATE_W-1:0]              date;
      logic [HANDLE_W-1:0]            handle;
   } entry_type;

   // Partial answer handed from cell to cell along the chain.
   typedef struct packed {
      logic                           hit;
      logic                           eq;
      entry_type                      ent;
   } token_type;

   // Request context broadcast to every cell.
   typedef struct packed {
      req_code_type                   code;
      logic [DATE_W-1:0]              key;
      logic [HANDLE_W-1:0]            handle;
      logic [ENTRY_INDEX_W-1:0]       idx;
      logic                           ins_commit;
      logic                           rem_commit;
   } cell_ctrl_type;

   function automatic logic [DATE_W-1:0] pack_date(
      input logic [YEAR_W-1:0]  y,
      input logic [MONTH_W-1:0] m,
      input logic [DAY_W-1:0]   d
   );
      return {y, m, d};
   endfunction

endpackage

>>> design/sorted_date_history_table.sv
// Channel   Direction  Handshake            Payload
// req_*     in         req_valid/req_stall  sdht_req_type: request code, date, handle, index
// rsp_*     out        rsp_valid/rsp_stall  sdht_rsp_type: status, found entry, entry count
//
// One request goes through accept, a sweep in which the answer token walks the
// cell chain, and a commit of the result and any shift of the entries.
// The sweep lasts until the token has passed every cell of the chain.
// Reset clears the entry count, the control state and the response valid; entries
// themselves are not cleared, since cells at or above the count are never read.
// A request is taken while a response still waits; its commit holds until the
// response register is free.
`include "sorted_date_history_table_assert.svh"

module sorted_date_history_table import sdht_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sdht_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sdht_rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SWP_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_COMMIT
   } state_type;

   state_type        state_ff;
   logic [SWP_W-1:0] sweep_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   sdht_req_type     req_ff;
   logic             rsp_valid_ff;
   sdht_rsp_type     rsp_ff, rsp_in;

   logic             accept, do_commit, ins_ok, rem_ok;
   logic [CNT_W+ENTRY_COUNT_W-1:0] count_wide;
   cell_ctrl_type    ctrl;
   token_type        last_tok;

   entry_type        ent [DEPTH];
   logic             lt  [DEPTH];
   token_type        tok [DEPTH];

   assign accept    = req_valid && !req_stall;
   assign do_commit = (state_ff == S_COMMIT) && (!rsp_valid_ff || !rsp_stall);
   assign last_tok  = tok[DEPTH-1];

   // Broadcast the held request to every cell; shift strobes fire only on commit.
   always_comb begin
      ctrl.code       = req_ff.req_type;
      ctrl.key        = pack_date(req_ff.year, req_ff.month, req_ff.day);
      ctrl.handle     = req_ff.value_handle;
      ctrl.idx        = req_ff.entry_index;
      ctrl.ins_commit = do_commit && ins_ok;
      ctrl.rem_commit = do_commit && rem_ok;
   end

   // Chain of cells: entries shift between neighbors, the answer token walks right.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_ent, right_ent;
      logic      left_lt;
      token_type tok_in;

      if (i == 0) begin : g_head
         assign left_ent = ent[0];
         assign left_lt  = 1'b1;
         assign tok_in   = '0;
      end else begin : g_body
         assign left_ent = ent[i-1];
         assign left_lt  = lt[i-1];
         assign tok_in   = tok[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_ent = ent[i];
      end else begin : g_mid
         assign right_ent = ent[i+1];
      end

      sdht_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .left_ent  (left_ent),
         .left_lt   (left_lt),
         .right_ent (right_ent),
         .tok_in    (tok_in),
         .ent_out   (ent[i]),
         .lt_out    (lt[i]),
         .tok_out   (tok[i])
      );
   end

   // Decide the result from the token that left the last cell.
   always_comb begin
      rsp_in   = '0;
      count_in = count_ff;
      ins_ok   = 1'b0;
      rem_ok   = 1'b0;
      unique case (req_ff.req_type) inside
         REQ_INSERT: begin
            // Duplicate check wins over the full check.
            if (last_tok.eq) begin
               rsp_in.status = ST_DUPLICATE;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_DONE;
               ins_ok        = 1'b1;
               count_in      = count_ff + 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (last_tok.eq) begin
               rsp_in.status = ST_DONE;
               rem_ok        = 1'b1;
               count_in      = count_ff - 1'b1;
            end else begin
               rsp_in.status = ST_MISSING;
            end
         end
         REQ_LOOKUP, REQ_READ: begin
            if (last_tok.hit) begin
               rsp_in.status       = ST_DONE;
               rsp_in.found_handle = last_tok.ent.handle;
               rsp_in.found_year   = last_tok.ent.date[DATE_W-1 -: YEAR_W];
               rsp_in.found_month  = last_tok.ent.date[DAY_W +: MONTH_W];
               rsp_in.found_day    = last_tok.ent.date[DAY_W-1:0];
            end else begin
               rsp_in.status = ST_MISSING;
            end
         end
         default: rsp_in.status = ST_MISSING;
      endcase
      count_wide         = (CNT_W + ENTRY_COUNT_W)'(count_in);
      rsp_in.entry_count = count_wide[ENTRY_COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               // Advance until the token has passed every cell.
               if (sweep_ff == SWP_W'(DEPTH - 1)) begin
                  state_ff <= S_COMMIT;
               end
            end
            S_COMMIT: begin
               if (do_commit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         if (do_commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Payload registers: no reset needed.
      if (accept) begin
         req_ff   <= req_payload;
         sweep_ff <= '0;
      end else if (state_ff == S_SWEEP) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
      if (do_commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SDHT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `SDHT_ASSERT_IMPLIES(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_COMMIT))
   `SDHT_ASSERT_NEXT(a_count_only_on_commit, clock, reset, !do_commit, $stable(count_ff))
   `SDHT_ASSERT_IMPLIES(a_full_means_full, clock, reset, rsp_valid_ff && (rsp_ff.status == ST_FULL), count_ff == CNT_W'(DEPTH))

endmodule

>>> design/sdht_cell.sv
module sdht_cell import sdht_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = $clog2(DEFAULT_DEPTH + 1)
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [CNT_W-1:0] count,
   input  entry_type        left_ent,
   input  logic             left_lt,
   input  entry_type        right_ent,
   input  token_type        tok_in,
   output entry_type        ent_out,
   output logic             lt_out,
   output token_type        tok_out
);

   localparam bit ADDRESSABLE = (INDEX < (1 << ENTRY_INDEX_W));

   entry_type ent_ff, ent_in;
   token_type tok_ff, tok_in_nxt;
   logic      valid, lt, eq, idx_hit, take;

   assign valid   = count > CNT_W'(INDEX);
   assign lt      = valid && (ent_ff.date < ctrl.key);
   assign eq      = valid && (ent_ff.date == ctrl.key);
   assign idx_hit = ADDRESSABLE && (ctrl.idx == ENTRY_INDEX_W'(INDEX));

   always_comb begin
      case (ctrl.code)
         REQ_LOOKUP: take = lt || eq;
         REQ_READ:   take = valid && idx_hit;
         default:    take = 1'b0;
      endcase
   end

   // Later cells hold later dates, so the last taker along the chain wins.
   always_comb begin
      tok_in_nxt    = tok_in;
      tok_in_nxt.eq = tok_in.eq || eq;
      if (take) begin
         tok_in_nxt.hit = 1'b1;
         tok_in_nxt.ent = ent_ff;
      end
   end

   // Insert: open a gap at the first entry not below the key.
   // Remove: close the gap from the matching entry onward.
   always_comb begin
      ent_in = ent_ff;
      if (ctrl.ins_commit && !lt) begin
         if (left_lt) begin
            ent_in.date   = ctrl.key;
            ent_in.handle = ctrl.handle;
         end else begin
            ent_in = left_ent;
         end
      end else if (ctrl.rem_commit && valid && !lt) begin
         ent_in = right_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      tok_ff <= tok_in_nxt;
   end

   assign ent_out = ent_ff;
   assign lt_out  = lt;
   assign tok_out = tok_ff;

endmodule
